// ===== src/lzme_pkg.sv =====
package lzme_pkg;

   localparam int WindowBytes   = 32;
   localparam int ByteWidth     = 8;
   localparam int OffsetWidth   = $clog2(WindowBytes);
   localparam int LengthWidth   = $clog2(WindowBytes + 1);
   localparam int CntWidth      = $clog2(WindowBytes + 1);
   localparam int ReqDataWidth  = 8;
   localparam int RspDataWidth  = 24;

   typedef enum logic {
      KIND_RAW   = 1'b0,
      KIND_TOKEN = 1'b1
   } kind_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 end_of_input;
   } in_word_type;

   typedef struct packed {
      kind_type               item_kind;
      logic [OffsetWidth-1:0] match_offset;
      logic [LengthWidth-1:0] match_length;
      logic [ByteWidth-1:0]   literal_byte;
      logic                   end_of_output;
   } token_type;

   function automatic logic [OffsetWidth-1:0] first_set(input logic [WindowBytes-1:0] vec);
      logic [OffsetWidth-1:0] idx;
      idx = '0;
      for (int i = WindowBytes - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = OffsetWidth'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== src/lzme_matcher.sv =====
module lzme_matcher (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  lzme_pkg::in_word_type word,
   output logic                  rslt_vld,
   output lzme_pkg::token_type   rslt
);

   logic [lzme_pkg::ByteWidth-1:0]   hist_ff [lzme_pkg::WindowBytes];
   logic [lzme_pkg::ByteWidth-1:0]   hist_in [lzme_pkg::WindowBytes];
   logic [lzme_pkg::ByteWidth-1:0]   cmp_ff  [lzme_pkg::WindowBytes];
   logic [lzme_pkg::ByteWidth-1:0]   cmp_in  [lzme_pkg::WindowBytes];
   logic [lzme_pkg::WindowBytes-1:0] cmpv_ff, cmpv_in;
   logic [lzme_pkg::WindowBytes-1:0] alive_ff, alive_in;
   logic [lzme_pkg::WindowBytes-1:0] hit;
   logic [lzme_pkg::CntWidth-1:0]    fill_ff, fill_in;
   logic [lzme_pkg::LengthWidth-1:0] matched_ff, matched_in;
   logic                             filling;
   logic                             any_hit;

   // history line: the most recent bytes of the stream, oldest at index 0
   always_comb begin
      for (int j = 0; j < lzme_pkg::WindowBytes - 1; j++) begin
         hist_in[j] = hist_ff[j+1];
      end
      hist_in[lzme_pkg::WindowBytes-1] = word.data_byte;
   end

   // compare line holds the frozen window advanced by the bytes matched so far
   always_comb begin
      for (int i = 0; i < lzme_pkg::WindowBytes; i++) begin
         hit[i] = alive_ff[i] & cmpv_ff[i] & (cmp_ff[i] == word.data_byte);
      end
   end

   assign any_hit = |hit;
   assign filling = fill_ff < lzme_pkg::CntWidth'(lzme_pkg::WindowBytes);

   always_comb begin
      cmp_in     = cmp_ff;
      cmpv_in    = cmpv_ff;
      alive_in   = alive_ff;
      fill_in    = fill_ff;
      matched_in = matched_ff;
      rslt_vld   = 1'b0;
      rslt.item_kind     = lzme_pkg::KIND_TOKEN;
      rslt.match_offset  = '0;
      rslt.match_length  = matched_ff;
      rslt.literal_byte  = word.data_byte;
      rslt.end_of_output = word.end_of_input;
      priority if (filling) begin
         rslt_vld           = 1'b1;
         rslt.item_kind     = lzme_pkg::KIND_RAW;
         rslt.match_length  = '0;
         if (word.end_of_input) begin
            fill_in  = '0;
            alive_in = '0;
         end else begin
            fill_in = fill_ff + 1'b1;
            if (fill_ff == lzme_pkg::CntWidth'(lzme_pkg::WindowBytes - 1)) begin
               cmp_in   = hist_in;
               cmpv_in  = '1;
               alive_in = '1;
            end
         end
      end else if (any_hit) begin
         matched_in = matched_ff + 1'b1;
         alive_in   = hit;
         for (int i = 0; i < lzme_pkg::WindowBytes - 1; i++) begin
            cmp_in[i] = cmp_ff[i+1];
         end
         cmp_in[lzme_pkg::WindowBytes-1] = word.data_byte;
         cmpv_in = {1'b0, cmpv_ff[lzme_pkg::WindowBytes-1:1]};
         if (word.end_of_input) begin
            // give up the last matched byte as the literal
            rslt_vld           = 1'b1;
            rslt.match_offset  = lzme_pkg::first_set(hit);
            rslt.match_length  = matched_ff;
            rslt.end_of_output = 1'b1;
            fill_in            = '0;
            matched_in         = '0;
            alive_in           = '0;
         end
      end else begin
         rslt_vld = 1'b1;
         if (matched_ff != '0) begin
            rslt.match_offset = lzme_pkg::first_set(alive_ff);
         end
         matched_in = '0;
         if (word.end_of_input) begin
            fill_in  = '0;
            alive_in = '0;
         end else begin
            cmp_in   = hist_in;
            cmpv_in  = '1;
            alive_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         matched_ff <= '0;
         alive_ff   <= '0;
         cmpv_ff    <= '0;
      end else if (step) begin
         fill_ff    <= fill_in;
         matched_ff <= matched_in;
         alive_ff   <= alive_in;
         cmpv_ff    <= cmpv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hist_ff <= hist_in;
         cmp_ff  <= cmp_in;
      end
   end

endmodule

// ===== src/lzme_out_reg.sv =====
module lzme_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lzme_pkg::token_type load_data,
   input  logic                take,
   output logic                out_vld,
   output lzme_pkg::token_type out_data
);

   logic                vld_ff, vld_in;
   lzme_pkg::token_type data_ff;

   always_comb begin
      priority if (load) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

// ===== src/lz77_match_encoder.sv =====
// LZ77 match encoder over a 32-byte window, one byte per word on the request
// side. The first 32 bytes of a stream come out raw (tuser 0); after that the
// window is frozen while every window position is compared with the arriving
// bytes in parallel, and a token (tuser 1: offset, length, literal) comes out
// when no candidate survives or the stream ends. A word with tlast closes the
// stream and the next word starts a fresh one. One byte is taken every cycle
// as long as the response side keeps up; a result reaches the response side
// through the input register and then the result register (the byte sits in
// the input register while the per-position byte comparators feed the result
// register). Bytes that only extend a match give no word.
module lz77_match_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lzme_pkg::ReqDataWidth-1:0]  req_tdata,  // [7:0] data_byte
   input  logic                               req_tlast,  // end_of_input
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [4:0] match_offset, [10:5] match_length, [18:11] literal_byte, rest zero
   output logic [lzme_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic                               rsp_tuser,  // item_kind
   output logic                               rsp_tlast   // end_of_output
);

   lzme_pkg::in_word_type in_ff;
   logic                  in_vld_ff, in_vld_in;
   logic                  fire;
   logic                  rslt_vld;
   lzme_pkg::token_type   rslt;
   lzme_pkg::token_type   out_data;

   assign fire       = in_vld_ff & (~rsp_tvalid | rsp_tready);
   assign req_tready = ~in_vld_ff | fire;

   always_comb begin
      priority if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.data_byte    <= req_tdata[lzme_pkg::ByteWidth-1:0];
         in_ff.end_of_input <= req_tlast;
      end
   end

   lzme_matcher u_matcher (
      .clock    (clock),
      .reset    (reset),
      .step     (fire),
      .word     (in_ff),
      .rslt_vld (rslt_vld),
      .rslt     (rslt)
   );

   lzme_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire & rslt_vld),
      .load_data (rslt),
      .take      (rsp_tready),
      .out_vld   (rsp_tvalid),
      .out_data  (out_data)
   );

   assign rsp_tdata = lzme_pkg::RspDataWidth'({out_data.literal_byte,
                                               out_data.match_length,
                                               out_data.match_offset});
   assign rsp_tuser = out_data.item_kind;
   assign rsp_tlast = out_data.end_of_output;

`ifndef ASSERT_OFF
   a_raw_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == lzme_pkg::KIND_RAW) |->
         (rsp_tdata[10:0] == 11'd0))
      else $error("raw word carries nonzero offset or length");

   a_match_in_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == lzme_pkg::KIND_TOKEN) |->
         ((7'(rsp_tdata[4:0]) + 7'(rsp_tdata[10:5])) <= 7'(lzme_pkg::WindowBytes)))
      else $error("token match runs past the window end");

   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_vld_ff)
      else $error("accepted byte lost before the input register");
`endif

endmodule

// ===== tb/sv/tb_lz77_match_encoder.sv =====
module tb_lz77_match_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [lzme_pkg::ReqDataWidth-1:0] req_tdata  = '0;
   logic                              req_tlast  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [lzme_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;

   lz77_match_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // encoder state as predicted
   bit [7:0]                       window_q[lzme_pkg::WindowBytes];
   bit [7:0]                       run_bytes[lzme_pkg::WindowBytes+1];
   bit [lzme_pkg::WindowBytes-1:0] live_starts;
   int unsigned                    run_len;
   int unsigned                    fill_len;

   lzme_pkg::token_type expected_tokens[$];
   bit [7:0]    stream_bytes[$];
   bit          no_gaps;
   int unsigned rsp_hold;
   int unsigned bytes_sent;
   int unsigned random_bytes;
   int unsigned streams_sent;
   int unsigned words_checked;
   int unsigned tokens_checked;
   int unsigned longest_match;
   int unsigned mismatches;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic void clear_encoder();
      window_q    = '{default: 8'h00};
      run_bytes   = '{default: 8'h00};
      live_starts = '0;
      run_len     = 0;
      fill_len    = 0;
   endfunction

   function automatic void shift_window(input bit [7:0] b);
      for (int i = 0; i < lzme_pkg::WindowBytes - 1; i++) window_q[i] = window_q[i+1];
      window_q[lzme_pkg::WindowBytes-1] = b;
   endfunction

   function automatic bit [lzme_pkg::OffsetWidth-1:0] earliest_start(
      input bit [lzme_pkg::WindowBytes-1:0] m);
      for (int i = 0; i < lzme_pkg::WindowBytes; i++) begin
         if (m[i]) return lzme_pkg::OffsetWidth'(i);
      end
      return '0;
   endfunction

   // return 1 when the byte produces a word
   function automatic bit encode_byte(input bit [7:0] b, input bit last,
                                      output lzme_pkg::token_type tok);
      bit [lzme_pkg::WindowBytes-1:0] still_live;
      tok = '0;
      tok.literal_byte  = b;
      tok.end_of_output = last;
      if (fill_len < lzme_pkg::WindowBytes) begin
         window_q[fill_len] = b;
         fill_len++;
         if (run_len == 0) live_starts = '1;
         tok.item_kind = lzme_pkg::KIND_RAW;
         if (last) clear_encoder();
         return 1'b1;
      end
      tok.item_kind = lzme_pkg::KIND_TOKEN;
      for (int i = 0; i < lzme_pkg::WindowBytes; i++) begin
         still_live[i] = live_starts[i] && (i + run_len < lzme_pkg::WindowBytes)
                         && window_q[i + run_len] == b;
      end
      if (still_live != '0) begin
         run_bytes[run_len] = b;
         run_len++;
         live_starts = still_live;
         if (!last) return 1'b0;
         tok.match_offset = earliest_start(live_starts);
         tok.match_length = lzme_pkg::LengthWidth'(run_len - 1);
         clear_encoder();
         return 1'b1;
      end
      tok.match_offset = (run_len == 0) ? '0 : earliest_start(live_starts);
      tok.match_length = lzme_pkg::LengthWidth'(run_len);
      if (last) begin
         clear_encoder();
         return 1'b1;
      end
      for (int i = 0; i < run_len; i++) shift_window(run_bytes[i]);
      shift_window(b);
      live_starts = '1;
      run_len     = 0;
      return 1'b1;
   endfunction

   task automatic send_byte(input bit [7:0] b, input bit last);
      int unsigned         gap;
      lzme_pkg::token_type tok;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (encode_byte(b, last, tok)) expected_tokens.push_back(tok);
   endtask

   task automatic send_stream();
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      streams_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < 100)
         $display("ERROR %0t word %0d: %s got 0x%0h expected 0x%0h",
                  $realtime, words_checked, what, got, want);
      mismatches++;
   endtask

   task automatic check_word();
      lzme_pkg::token_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch("unexpected word", rsp_tdata, 0);
         return;
      end
      want = expected_tokens.pop_front();
      if (rsp_tuser !== want.item_kind)
         report_mismatch("item_kind", rsp_tuser, want.item_kind);
      if (rsp_tdata[4:0] !== want.match_offset)
         report_mismatch("match_offset", rsp_tdata[4:0], want.match_offset);
      if (rsp_tdata[10:5] !== want.match_length)
         report_mismatch("match_length", rsp_tdata[10:5], want.match_length);
      if (rsp_tdata[18:11] !== want.literal_byte)
         report_mismatch("literal_byte", rsp_tdata[18:11], want.literal_byte);
      if (rsp_tdata[23:19] !== 5'd0)
         report_mismatch("padding", rsp_tdata[23:19], 0);
      if (rsp_tlast !== want.end_of_output)
         report_mismatch("end_of_output", rsp_tlast, want.end_of_output);
      if (want.item_kind == lzme_pkg::KIND_TOKEN) tokens_checked++;
      if (want.match_length > longest_match) longest_match = want.match_length;
      words_checked++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word();
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = pick_gap();
      end
   end

   task automatic test_short_streams();
      stream_bytes = '{8'h00};
      send_stream();
      stream_bytes = '{8'hFF, 8'hA5, 8'h5A};
      send_stream();
      stream_bytes = {};
      for (int i = 0; i < lzme_pkg::WindowBytes; i++)
         stream_bytes.push_back(i[0] ? 8'hFF : 8'h00);
      send_stream();
   endtask

   // full-window match at offset 0, a zero-length token, then a match cut by the end
   task automatic test_full_window_match();
      stream_bytes = {};
      for (int i = 0; i < lzme_pkg::WindowBytes; i++) stream_bytes.push_back(8'(i * 8 + 3));
      for (int i = 0; i < lzme_pkg::WindowBytes; i++) stream_bytes.push_back(8'(i * 8 + 3));
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hFE);
      stream_bytes.push_back(8'(5 * 8 + 3));
      stream_bytes.push_back(8'(6 * 8 + 3));
      stream_bytes.push_back(8'(7 * 8 + 3));
      send_stream();
   endtask

   task automatic test_break_on_last_byte();
      stream_bytes = {};
      repeat (lzme_pkg::WindowBytes + 2) stream_bytes.push_back(8'h33);
      stream_bytes.push_back(8'h44);
      send_stream();
   endtask

   task automatic build_random_stream();
      int unsigned r;
      int unsigned body;
      int unsigned back_dist;
      int unsigned run;
      bit [7:0]    alphabet[4];
      bit          narrow;
      foreach (alphabet[i]) alphabet[i] = 8'($urandom);
      stream_bytes = {};
      r = $urandom_range(0, 9);
      if (r == 0) begin
         repeat ($urandom_range(1, lzme_pkg::WindowBytes))
            stream_bytes.push_back(8'($urandom));
         return;
      end
      if (r == 1) begin
         repeat ($urandom_range(lzme_pkg::WindowBytes + 1, 90))
            stream_bytes.push_back(8'($urandom));
         return;
      end
      narrow = $urandom_range(0, 1);
      repeat (lzme_pkg::WindowBytes) begin
         if (narrow) stream_bytes.push_back(alphabet[$urandom_range(0, 3)]);
         else stream_bytes.push_back(8'($urandom));
      end
      body = $urandom_range(1, 70);
      while (stream_bytes.size() < lzme_pkg::WindowBytes + body) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            back_dist = $urandom_range(1, lzme_pkg::WindowBytes);
            run       = $urandom_range(1, lzme_pkg::WindowBytes + 2);
            repeat (run)
               stream_bytes.push_back(stream_bytes[stream_bytes.size() - back_dist]);
         end else if (r < 8) begin
            stream_bytes.push_back(8'($urandom));
         end else begin
            stream_bytes.push_back(alphabet[$urandom_range(0, 3)]);
         end
      end
   endtask

   task automatic test_random_streams();
      int unsigned n;
      int unsigned start;
      n = 0;
      while (random_bytes < 640) begin
         no_gaps = (n >= 5 && n < 8);
         if (n == 3) wait_for_drain();
         build_random_stream();
         start = bytes_sent;
         send_stream();
         random_bytes += bytes_sent - start;
         n++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      clear_encoder();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_short_streams();
      test_full_window_match();
      test_break_on_last_byte();
      test_random_streams();
      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d streams; checked %0d words, %0d of them tokens.",
               bytes_sent, streams_sent, words_checked, tokens_checked);
      $display("Longest match seen: %0d bytes; mismatches: %0d.", longest_match, mismatches);
      if (mismatches == 0 && expected_tokens.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d words still expected", expected_tokens.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
src/lzme_pkg.sv
src/lzme_matcher.sv
src/lzme_out_reg.sv
src/lz77_match_encoder.sv
tb/sv/tb_lz77_match_encoder.sv
